[hw/rtl/aitken_extrapolator_macros.svh]
// ----------------------------------------------------------------------------
// Aitken extrapolator assertion macros
// Concurrent assertion wrappers on clk, disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AITKEN_EXTRAPOLATOR_MACROS_SVH
`define AITKEN_EXTRAPOLATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AITK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aitken_extrapolator: assertion failed");
// next-cycle implication
`define AITK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aitken_extrapolator: assertion failed");
`else
`define AITK_ASSERT_IMP(lbl, ante, cons)
`define AITK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/aitk_pkg.sv]
// ----------------------------------------------------------------------------
// Aitken extrapolator package
// Widths, status codes, constants and divider handshake types.
// ----------------------------------------------------------------------------
package aitk_pkg;

  localparam int VALUE_WIDTH    = 48;
  localparam int FRAC_BITS      = 24;
  localparam int MAX_COMPONENTS = 64;
  localparam int COMP_WIDTH     = 6;
  localparam int IDX_WIDTH      = $clog2(MAX_COMPONENTS);
  localparam int STATUS_WIDTH   = 2;

  // differences of two values, their difference, and the wide quotient path
  localparam int DIFF_WIDTH = VALUE_WIDTH + 1;
  localparam int DEN_WIDTH  = VALUE_WIDTH + 2;
  localparam int NUM_WIDTH  = 2 * DIFF_WIDTH - 1;
  localparam int SUM_WIDTH  = NUM_WIDTH + 2;
  localparam int CNT_WIDTH  = $clog2(NUM_WIDTH + 1);

  // split of |d0| for the shared multiplier
  localparam int LO_WIDTH   = DIFF_WIDTH / 2;
  localparam int HI_WIDTH   = DIFF_WIDTH - LO_WIDTH;
  localparam int PROD_WIDTH = 2 * HI_WIDTH;

  localparam int RATE_ITERS = DIFF_WIDTH + FRAC_BITS;
  localparam int CORR_ITERS = NUM_WIDTH;

  localparam int IN_DATA_WIDTH  = ((COMP_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((COMP_WIDTH + 2 * VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_NO_HIST  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_D1_ZERO  = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_DEN_ZERO = 2'd3;

  // -1.0 in the value format
  localparam logic [VALUE_WIDTH-1:0] RATE_NO_HIST =
    {{(VALUE_WIDTH - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

  // saturation limits on the quotient magnitude
  localparam logic [NUM_WIDTH-1:0] MAG_POS_LIM =
    {{(NUM_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [NUM_WIDTH-1:0] MAG_NEG_LIM =
    {{(NUM_WIDTH - VALUE_WIDTH){1'b0}}, 1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  // saturation limits on the signed extrapolate sum
  localparam logic [SUM_WIDTH-1:0] SUM_MAX =
    {{(SUM_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN =
    {{(SUM_WIDTH - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic                 start;
    logic [CNT_WIDTH-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

[hw/rtl/aitk_div.sv]
// ----------------------------------------------------------------------------
// Aitken extrapolator divider
// Restoring unsigned divider, one quotient bit per cycle; numerator is taken
// left-aligned and the iteration count sets how many of its bits are used.
// ----------------------------------------------------------------------------
module aitk_div (
  input  logic                           clk,
  input  logic                           rst,
  input  aitk_pkg::div_req_t             req,
  input  logic [aitk_pkg::NUM_WIDTH-1:0] num,
  input  logic [aitk_pkg::DEN_WIDTH-1:0] divisor,
  output aitk_pkg::div_rsp_t             rsp,
  output logic [aitk_pkg::NUM_WIDTH-1:0] quot
);

  localparam int REM_WIDTH = aitk_pkg::DEN_WIDTH + 1;

  logic [aitk_pkg::CNT_WIDTH-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [aitk_pkg::NUM_WIDTH-1:0] nreg;
  logic [aitk_pkg::DEN_WIDTH-1:0] dreg;
  logic [REM_WIDTH-1:0]           rem;
  logic [REM_WIDTH-1:0]           shifted;
  logic [REM_WIDTH:0]             trial;
  logic                           ge;

  assign shifted = {rem[REM_WIDTH-2:0], nreg[aitk_pkg::NUM_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dreg};
  assign ge      = ~trial[REM_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == aitk_pkg::CNT_WIDTH'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == aitk_pkg::CNT_WIDTH'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nreg <= num;
      dreg <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      nreg <= {nreg[aitk_pkg::NUM_WIDTH-2:0], 1'b0};
      rem  <= ge ? trial[REM_WIDTH-1:0] : shifted;
      quot <= {quot[aitk_pkg::NUM_WIDTH-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

[hw/rtl/aitken_extrapolator.sv]
// ----------------------------------------------------------------------------
// Aitken delta-squared extrapolator
// Vectors stream in one component per transfer (index, signed Q23.24 sample,
// tlast on the last component). For each component the block keeps the two
// previous samples j0 (older) and j1 (newer) in on-chip history memories and
// returns one result per transfer: rate = d0/d1 and extrapolate
// j0 - d0*d0/(d0-d1), with d0 = j0-j1 and d1 = j1-j2, both quotients
// truncated toward zero, both results saturated to 48 bits. Until two whole vectors
// have passed, results are 0 with rate -1.0 and status "too little history";
// d1 = 0 gives status 2, d0 = d1 gives status 3, both with zero outputs.
// One item at a time: s_tready is high only while the sequencer is idle.
// An item with full history goes from the input transfer through READ, DEN and
// CHK, a 73-step rate pass of the shared one-bit-per-cycle divider, RSAT, the
// shared 25x25 multiplier building d0*d0 in four steps, CSTART, a 97-step
// correction pass of the divider, EXT and FIN, where its result is registered.
// Items that end with a nonzero status go from CHK straight to FIN.
// A finished result waits in the output register without holding up the
// next transfer; only a result still waiting when the next one is finished
// stalls the sequencer.
// History entries are not cleared by reset: each component
// must be written once (appear in a vector) before it is read with history.
// ----------------------------------------------------------------------------
`include "aitken_extrapolator_macros.svh"

module aitken_extrapolator (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [5:0] component, [53:6] sample, [55:54] zero
  input  logic [aitk_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  // end_of_vector
  input  logic                                s_tlast,
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [5:0] component_out, [53:6] extrapolated, [101:54] rate, [103:102] zero
  output logic [aitk_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  // [1:0] status
  output logic [aitk_pkg::STATUS_WIDTH-1:0]   m_tuser
);

  localparam int VW   = aitk_pkg::VALUE_WIDTH;
  localparam int CW   = aitk_pkg::COMP_WIDTH;
  localparam int DW   = aitk_pkg::DIFF_WIDTH;
  localparam int EW   = aitk_pkg::DEN_WIDTH;
  localparam int NW   = aitk_pkg::NUM_WIDTH;
  localparam int SW   = aitk_pkg::SUM_WIDTH;
  localparam int LW   = aitk_pkg::LO_WIDTH;
  localparam int HW   = aitk_pkg::HI_WIDTH;
  localparam int PW   = aitk_pkg::PROD_WIDTH;
  localparam int PADW = aitk_pkg::OUT_DATA_WIDTH - CW - 2 * VW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;  // history data ready, form d0 / d1
  localparam logic [3:0] S_DEN    = 4'd2;  // magnitudes, d0 - d1
  localparam logic [3:0] S_CHK    = 4'd3;  // status, launch rate division
  localparam logic [3:0] S_DIVR   = 4'd4;
  localparam logic [3:0] S_RSAT   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;  // d0*d0 in four steps
  localparam logic [3:0] S_CSTART = 4'd7;  // launch correction division
  localparam logic [3:0] S_DIVC   = 4'd8;
  localparam logic [3:0] S_EXT    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;
  logic [1:0] mcnt;
  logic [1:0] vectors_seen;
  logic       s_fire;
  logic       out_load;

  // history memories
  logic [VW-1:0] older_mem [aitk_pkg::MAX_COMPONENTS];
  logic [VW-1:0] newer_mem [aitk_pkg::MAX_COMPONENTS];

  logic [aitk_pkg::IDX_WIDTH-1:0] in_idx;
  logic [CW-1:0]                  comp;
  logic [VW-1:0]                  j2;
  logic                           hist;
  logic [VW-1:0]                  rd_older;
  logic [VW-1:0]                  rd_newer;

  logic signed [DW-1:0] d0;
  logic signed [DW-1:0] d1;
  logic [DW-1:0]        d0m;
  logic [DW-1:0]        d1m;
  logic                 d0n;
  logic                 d1n;
  logic signed [EW-1:0] den;
  logic [EW-1:0]        denm;
  logic                 den_neg;

  logic [aitk_pkg::STATUS_WIDTH-1:0] status;
  logic                              status_ok;
  logic [VW-1:0]                     rate_res;
  logic signed [SW-1:0]              ext_sum;

  // shared multiplier
  logic [HW-1:0] mop_a;
  logic [HW-1:0] mop_b;
  logic [PW-1:0] prod;
  logic [NW-1:0] acc;

  // shared divider
  aitk_pkg::div_req_t      div_req;
  aitk_pkg::div_rsp_t      div_rsp;
  logic [NW-1:0]           div_num;
  logic [EW-1:0]           div_den;
  logic [NW-1:0]           div_q;
  logic [NW-1:0]           rate_mag;
  logic [NW-1:0]           rate_lim;
  logic                    rate_neg;
  logic signed [SW-1:0]    q_ext;
  logic signed [SW-1:0]    j0_ext;

  // output register
  logic [CW-1:0]                     o_comp;
  logic [VW-1:0]                     o_ext;
  logic [VW-1:0]                     o_rate;
  logic [aitk_pkg::STATUS_WIDTH-1:0] o_status;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign in_idx   = s_tdata[aitk_pkg::IDX_WIDTH-1:0];
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // status of the item, history checked first
  always_comb begin
    if (!hist) begin
      status_ok = 1'b0;
    end else if (d1 == '0) begin
      status_ok = 1'b0;
    end else if (den == '0) begin
      status_ok = 1'b0;
    end else begin
      status_ok = 1'b1;
    end
  end

  // divider launch: rate numerator is |d0| << FRAC_BITS, left-aligned
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = aitk_pkg::CNT_WIDTH'(aitk_pkg::RATE_ITERS);
    div_num       = {d0m, {(NW - DW){1'b0}}};
    div_den       = EW'(d1m);
    case (state)
      S_CHK: begin
        div_req.start = status_ok;
      end
      S_CSTART: begin
        div_req.start = 1'b1;
        div_req.iters = aitk_pkg::CNT_WIDTH'(aitk_pkg::CORR_ITERS);
        div_num       = acc;
        div_den       = denm;
      end
      default: begin
      end
    endcase
  end

  aitk_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .num     (div_num),
    .divisor (div_den),
    .rsp     (div_rsp),
    .quot    (div_q)
  );

  // multiplier operand select: a0*a0, a0*a1, a1*a1
  always_comb begin
    case (mcnt)
      2'd0: begin
        mop_a = HW'(d0m[LW-1:0]);
        mop_b = HW'(d0m[LW-1:0]);
      end
      2'd1: begin
        mop_a = HW'(d0m[LW-1:0]);
        mop_b = d0m[DW-1:LW];
      end
      default: begin
        mop_a = d0m[DW-1:LW];
        mop_b = d0m[DW-1:LW];
      end
    endcase
  end

  assign rate_neg = d0n ^ d1n;
  assign rate_lim = rate_neg ? aitk_pkg::MAG_NEG_LIM : aitk_pkg::MAG_POS_LIM;
  assign rate_mag = (div_q > rate_lim) ? rate_lim : div_q;
  assign q_ext    = $signed({2'b00, div_q});
  assign j0_ext   = $signed({{(SW - VW){rd_older[VW-1]}}, rd_older});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mcnt         <= 2'd0;
      vectors_seen <= 2'd0;
      m_tvalid     <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            state <= S_READ;
            if (s_tlast && vectors_seen != 2'd2) begin
              vectors_seen <= vectors_seen + 2'd1;
            end
          end
        end
        S_READ: state <= S_DEN;
        S_DEN:  state <= S_CHK;
        S_CHK:  state <= status_ok ? S_DIVR : S_FIN;
        S_DIVR: begin
          if (div_rsp.done) begin
            state <= S_RSAT;
          end
        end
        S_RSAT: begin
          state <= S_MUL;
          mcnt  <= 2'd0;
        end
        S_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            state <= S_CSTART;
          end
        end
        S_CSTART: state <= S_DIVC;
        S_DIVC: begin
          if (div_rsp.done) begin
            state <= S_EXT;
          end
        end
        S_EXT: state <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // history memories: read on the input transfer, written back in the READ state
  always_ff @(posedge clk) begin
    if (s_fire) begin
      rd_older <= older_mem[in_idx];
      rd_newer <= newer_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      older_mem[comp[aitk_pkg::IDX_WIDTH-1:0]] <= rd_newer;
      newer_mem[comp[aitk_pkg::IDX_WIDTH-1:0]] <= j2;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          comp <= s_tdata[CW-1:0];
          j2   <= s_tdata[CW+VW-1:CW];
          hist <= (vectors_seen == 2'd2);
        end
      end
      S_READ: begin
        d0 <= $signed({rd_older[VW-1], rd_older}) - $signed({rd_newer[VW-1], rd_newer});
        d1 <= $signed({rd_newer[VW-1], rd_newer}) - $signed({j2[VW-1], j2});
      end
      S_DEN: begin
        d0n <= d0[DW-1];
        d1n <= d1[DW-1];
        d0m <= d0[DW-1] ? DW'(-d0) : DW'(d0);
        d1m <= d1[DW-1] ? DW'(-d1) : DW'(d1);
        den <= EW'(d0) - EW'(d1);
      end
      S_CHK: begin
        den_neg  <= den[EW-1];
        denm     <= den[EW-1] ? EW'(-den) : EW'(den);
        rate_res <= hist ? '0 : aitk_pkg::RATE_NO_HIST;
        if (!hist) begin
          status <= aitk_pkg::ST_NO_HIST;
        end else if (d1 == '0) begin
          status <= aitk_pkg::ST_D1_ZERO;
        end else if (den == '0) begin
          status <= aitk_pkg::ST_DEN_ZERO;
        end else begin
          status <= aitk_pkg::ST_OK;
        end
      end
      S_RSAT: begin
        rate_res <= rate_neg ? VW'(-rate_mag) : VW'(rate_mag);
      end
      S_MUL: begin
        prod <= mop_a * mop_b;
        case (mcnt)
          2'd0:    acc <= '0;
          2'd1:    acc <= acc + NW'(prod);
          2'd2:    acc <= acc + (NW'(prod) << (LW + 1));
          default: acc <= acc + (NW'(prod) << (2 * LW));
        endcase
      end
      S_EXT: begin
        // j0 - c, with c carrying the sign of d0 - d1
        ext_sum <= den_neg ? (j0_ext + q_ext) : (j0_ext - q_ext);
      end
      default: begin
      end
    endcase
  end

  // output register; saturated extrapolate is taken straight from the
  // compare so the FIN cycle does both
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_comp   <= comp;
      o_rate   <= rate_res;
      o_status <= status;
      if (status != aitk_pkg::ST_OK) begin
        o_ext <= '0;
      end else if (ext_sum > $signed(aitk_pkg::SUM_MAX)) begin
        o_ext <= aitk_pkg::SUM_MAX[VW-1:0];
      end else if (ext_sum < $signed(aitk_pkg::SUM_MIN)) begin
        o_ext <= aitk_pkg::SUM_MIN[VW-1:0];
      end else begin
        o_ext <= ext_sum[VW-1:0];
      end
    end
  end

  assign m_tdata = {{PADW{1'b0}}, o_rate, o_ext, o_comp};
  assign m_tuser = o_status;

  // assertions
  `AITK_ASSERT_IMP(a_ready_div_idle, s_tready, !div_rsp.busy)
  `AITK_ASSERT_IMP(a_done_in_div_state, div_rsp.done,
                   (state == S_DIVR) || (state == S_DIVC))
  `AITK_ASSERT_IMP(a_no_hist_result, m_tvalid && (m_tuser == aitk_pkg::ST_NO_HIST),
                   (o_rate == aitk_pkg::RATE_NO_HIST) && (o_ext == '0))
  `AITK_ASSERT_NXT(a_vector_count, s_fire && s_tlast && (vectors_seen != 2'd2),
                   vectors_seen == $past(vectors_seen) + 2'd1)

endmodule

[sim/aitken_extrapolator_checker.sv]
// ----------------------------------------------------------------------------
// Aitken extrapolator result checker
// Watches both stream channels. It predicts one result per input transfer
// from its own copy of the per-component history. Each output transfer is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module aitken_extrapolator_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [aitk_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  input  logic                                s_tlast,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [aitk_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic [aitk_pkg::STATUS_WIDTH-1:0]   m_tuser,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam int VW = aitk_pkg::VALUE_WIDTH;
  localparam int CW = aitk_pkg::COMP_WIDTH;

  typedef struct packed {
    logic [CW-1:0]                     comp;
    logic [VW-1:0]                     extrap;
    logic [VW-1:0]                     rate;
    logic [aitk_pkg::STATUS_WIDTH-1:0] status;
  } aitken_result_t;

  localparam logic signed [127:0] LIM_HI = (128'sd1 <<< (VW - 1)) - 128'sd1;
  localparam logic signed [127:0] LIM_LO = -(128'sd1 <<< (VW - 1));

  logic signed [VW-1:0] hist_old [aitk_pkg::MAX_COMPONENTS];
  logic signed [VW-1:0] hist_new [aitk_pkg::MAX_COMPONENTS];
  int                   full_vectors;
  aitken_result_t       expected_results [$];

  initial begin
    for (int i = 0; i < aitk_pkg::MAX_COMPONENTS; i++) begin
      hist_old[i] = '0;
      hist_new[i] = '0;
    end
    full_vectors = 0;
    mismatches   = 0;
    outstanding  = 0;
  end

  function automatic logic [VW-1:0] clamp(input logic signed [127:0] v);
    if (v > LIM_HI) return LIM_HI[VW-1:0];
    if (v < LIM_LO) return LIM_LO[VW-1:0];
    return v[VW-1:0];
  endfunction

  // predicts the result of one component and advances its history
  function automatic aitken_result_t aitken_step(input logic [CW-1:0] comp,
                                                 input logic signed [VW-1:0] sample,
                                                 input logic last);
    aitken_result_t                 r;
    logic [aitk_pkg::IDX_WIDTH-1:0] idx;
    logic signed [127:0]            j0, j1, j2, d0, d1, den;
    idx      = aitk_pkg::IDX_WIDTH'(comp);
    j0       = 128'(hist_old[idx]);
    j1       = 128'(hist_new[idx]);
    j2       = 128'(sample);
    r.comp   = comp;
    r.extrap = '0;
    r.rate   = '0;
    if (full_vectors < 2) begin
      r.rate   = aitk_pkg::RATE_NO_HIST;
      r.status = aitk_pkg::ST_NO_HIST;
    end else begin
      d0  = j0 - j1;
      d1  = j1 - j2;
      den = d0 - d1;
      if (d1 == 0) begin
        r.status = aitk_pkg::ST_D1_ZERO;
      end else if (den == 0) begin
        r.status = aitk_pkg::ST_DEN_ZERO;
      end else begin
        // signed division truncates toward zero; only the final values clamp
        r.rate   = clamp((d0 <<< aitk_pkg::FRAC_BITS) / d1);
        r.extrap = clamp(j0 - (d0 * d0) / den);
        r.status = aitk_pkg::ST_OK;
      end
    end
    hist_old[idx] = hist_new[idx];
    hist_new[idx] = sample;
    if (last && full_vectors < 2) full_vectors++;
    return r;
  endfunction

  task automatic flag(input string field, input logic [63:0] want_v, input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    aitken_result_t want, got;
    got.comp   = m_tdata[CW-1:0];
    got.extrap = m_tdata[CW +: VW];
    got.rate   = m_tdata[CW + VW +: VW];
    got.status = m_tuser;
    if (expected_results.size() == 0) begin
      $display("%0t unexpected result: expected none actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    flag("component", 64'(want.comp), 64'(got.comp));
    flag("extrapolated", 64'(want.extrap), 64'(got.extrap));
    flag("rate", 64'(want.rate), 64'(got.rate));
    flag("status", 64'(want.status), 64'(got.status));
  endtask

  // output side first: a result can never belong to an input of the same edge
  always @(posedge clk) begin
    if (rst) begin
      full_vectors = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                aitken_step(s_tdata[CW-1:0],
                                            s_tdata[CW +: VW],
                                            s_tlast));
    end
    outstanding = expected_results.size();
  end

endmodule

[sim/aitken_extrapolator_tb.sv]
// ----------------------------------------------------------------------------
// Aitken extrapolator testbench
// Warms up the history with two full vectors over all components. Then it
// runs directed cases (zero d1, equal differences, saturation of rate and
// extrapolate, field extremes), then random vectors in four idling phases.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module aitken_extrapolator_tb;

  localparam int VW    = aitk_pkg::VALUE_WIDTH;
  localparam int CW    = aitk_pkg::COMP_WIDTH;
  localparam int NCOMP = aitk_pkg::MAX_COMPONENTS;
  localparam int FB    = aitk_pkg::FRAC_BITS;

  localparam int ITEMS_PER_PHASE = 265;
  localparam int STALL_LIMIT     = 4000;  // quiet cycles
  localparam int TAIL_CYCLES     = 250;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // sample shapes used once history exists
  typedef enum int {
    PAT_CONVERGE, PAT_REPEAT, PAT_ARITH, PAT_WIDE, PAT_EXTREME, PAT_NEAR
  } pattern_t;

  logic                                clk      = 1'b0;
  logic                                rst      = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic [aitk_pkg::IN_DATA_WIDTH-1:0]  s_tdata  = '0;
  logic                                s_tlast  = 1'b0;
  logic                                m_tready = 1'b0;
  logic                                s_tready;
  logic                                m_tvalid;
  logic [aitk_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
  logic [aitk_pkg::STATUS_WIDTH-1:0]   m_tuser;

  int mismatches;
  int outstanding;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int quiet_cycles  = 0;

  // phase table: sender idle and receiver stall, percent of cycles
  int src_idle_tab [4] = '{0, 72, 0, 6};
  int snk_stall_tab[4] = '{0, 0, 72, 6};

  // stimulus-side copy of the history, used only to shape samples
  logic signed [VW-1:0] mir_old [NCOMP];
  logic signed [VW-1:0] mir_new [NCOMP];

  aitken_extrapolator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  aitken_extrapolator_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one input transfer; valid stays high into the next item unless idling
  task automatic push_item(input logic [CW-1:0] comp,
                           input logic signed [VW-1:0] sample,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= aitk_pkg::IN_DATA_WIDTH'({sample, comp});
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mir_old[comp] = mir_new[comp];
    mir_new[comp] = sample;
  endtask

  function automatic logic signed [VW-1:0] shaped_sample(
      input pattern_t pat, input logic [CW-1:0] comp);
    logic signed [63:0] j0, j1, v;
    logic signed [VW-1:0] rnd;
    int                 k;
    j0  = 64'(mir_old[comp]);
    j1  = 64'(mir_new[comp]);
    rnd = VW'({$urandom, $urandom});
    case (pat)
      PAT_CONVERGE: begin
        // next difference is a random fraction of the last one
        k = $urandom_range(30) - 15;
        v = j1 + ((j0 - j1) * k) / 16;
      end
      PAT_REPEAT: v = j1;               // d1 zero
      PAT_ARITH:  v = 2 * j1 - j0;      // equal differences
      PAT_EXTREME: begin
        case ($urandom_range(3))
          0:       v = 64'(VAL_MAX);
          1:       v = 64'(VAL_MIN);
          2:       v = '0;
          default: v = '1;
        endcase
      end
      PAT_NEAR: begin
        k = $urandom_range(2000) - 1000;
        v = j1 + k;
      end
      default: v = 64'(rnd);
    endcase
    if (v > VAL_MAX || v < VAL_MIN) v = 64'(rnd);
    return v[VW-1:0];
  endfunction

  function automatic pattern_t pick_pattern();
    case ($urandom_range(9))
      0, 1, 2, 3: return PAT_CONVERGE;
      4:          return PAT_REPEAT;
      5:          return PAT_ARITH;
      6:          return PAT_WIDE;
      7:          return PAT_EXTREME;
      default:    return PAT_NEAR;
    endcase
  endfunction

  initial begin
    logic [CW-1:0] comp;
    for (int i = 0; i < NCOMP; i++) begin
      mir_old[i] = '0;
      mir_new[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // warm-up: every component written twice before any history read;
    // all results here report too little history
    for (int k = 0; k < NCOMP; k++) begin
      comp = CW'(k);
      if (k == 0) push_item(comp, VAL_MAX, 1'b0);
      else if (k == 1) push_item(comp, VAL_MIN, 1'b0);
      else push_item(comp, VW'({$urandom, $urandom}), k == NCOMP - 1);
    end
    for (int k = NCOMP - 1; k >= 0; k--) begin
      comp = CW'(k);
      if (k == NCOMP - 1) push_item(comp, '0, 1'b0);
      else if (k == NCOMP - 2) push_item(comp, -48'sd1, 1'b0);
      else push_item(comp, VW'({$urandom, $urandom}), k == 0);
    end

    // directed: arithmetic run, then zero d1, zero d0, full-swing steps
    push_item(6'd10, 48'sd1000, 1'b0);
    push_item(6'd10, 48'sd2000, 1'b0);
    push_item(6'd10, 48'sd3000, 1'b0);        // d0 equals d1
    push_item(6'd10, 48'sd3000, 1'b0);        // d1 zero
    push_item(6'd10, VAL_MAX, 1'b0);          // d0 zero
    push_item(6'd10, VAL_MIN, 1'b0);
    push_item(6'd10, VAL_MIN + 48'sd1, 1'b0); // rate saturates negative
    // halving steps: rate 2.0, limit exactly 2.0
    push_item(6'd11, 48'sd0, 1'b0);
    push_item(6'd11, 48'sd1 <<< FB, 1'b0);
    push_item(6'd11, (48'sd1 <<< FB) + (48'sd1 <<< (FB - 1)), 1'b0);
    // opposite extremes, then a unit step
    push_item(6'd12, VAL_MIN, 1'b0);
    push_item(6'd12, VAL_MAX, 1'b0);
    push_item(6'd12, VAL_MAX - 48'sd1, 1'b0);
    // denominator -1: extrapolate saturates high
    push_item(6'd13, 48'sd1 <<< 40, 1'b0);
    push_item(6'd13, (48'sd1 <<< 40) - (48'sd1 <<< 30), 1'b0);
    push_item(6'd13, (48'sd1 <<< 40) - (48'sd1 <<< 31) - 48'sd1, 1'b0);
    // denominator +1: extrapolate saturates low
    push_item(6'd14, -(48'sd1 <<< 40), 1'b0);
    push_item(6'd14, -(48'sd1 <<< 40) - (48'sd1 <<< 30), 1'b0);
    push_item(6'd14, -(48'sd1 <<< 40) - (48'sd1 <<< 31) + 48'sd1, 1'b0);
    // d1 of one against a huge d0: rate saturates high
    push_item(6'd15, 48'sd0, 1'b0);
    push_item(6'd15, -(48'sd1 <<< 46), 1'b0);
    push_item(6'd15, -(48'sd1 <<< 46) - 48'sd1, 1'b1);

    // random vectors over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_idle_tab[ph];
      snk_stall_pct = snk_stall_tab[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        comp = CW'($urandom_range(NCOMP - 1));
        push_item(comp, shaped_sample(pick_pattern(), comp), $urandom_range(15) == 0);
      end
    end
    s_tvalid <= 1'b0;
    snk_stall_pct = 0;

    // drain, then give stray results time to show up
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
